// ----- src/assert_macros.svh -----
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is low
`define FSC_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");

// clocked assertion that also holds during reset
`define FSC_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

// ----- src/fsc_pkg.sv -----
// shared types and constants of the frustum sphere culler
// no dependencies
package fsc_pkg;

    localparam logic        OP_LOAD   = 1'b0;
    localparam logic        OP_TEST   = 1'b1;
    localparam logic [1:0]  COL_LAST  = 2'd3;
    localparam logic [30:0] RAD_RESET = 31'd65536;
    localparam logic [46:0] SAT_MAG   = '1;

    typedef struct packed {
        logic       load_col;
        logic       capture;
        logic       build;
        logic       halve;
        logic       acc_clr;
        logic       sq_mul;
        logic       t_mul;
        logic       acc_add;
        logic       sqrt_init;
        logic       sqrt_step;
        logic       div_init;
        logic       div_step;
        logic       div_wr;
        logic       out_load;
        logic [2:0] plane;
        logic [1:0] coef;
    } t_cmd;

    typedef struct packed {
        logic reject;
        logic out_free;
    } t_sts;

endpackage

// ----- src/fsc_ctrl.sv -----
// controller state machine of the frustum sphere culler
// depends on fsc_pkg
module fsc_ctrl (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_ready,
    input  logic         i_opcode,
    input  logic [1:0]   i_column_index,
    input  logic         i_visible_in,
    input  fsc_pkg::t_sts i_sts,
    output fsc_pkg::t_cmd o_cmd
);
    import fsc_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_BUILD = 4'd1;
    localparam logic [3:0] S_HALVE = 4'd2;
    localparam logic [3:0] S_SQM   = 4'd3;
    localparam logic [3:0] S_SQA   = 4'd4;
    localparam logic [3:0] S_SQI   = 4'd5;
    localparam logic [3:0] S_SQRT  = 4'd6;
    localparam logic [3:0] S_DIVI  = 4'd7;
    localparam logic [3:0] S_DIVS  = 4'd8;
    localparam logic [3:0] S_DIVW  = 4'd9;
    localparam logic [3:0] S_TMUL  = 4'd10;
    localparam logic [3:0] S_TACC  = 4'd11;
    localparam logic [3:0] S_TCMP  = 4'd12;
    localparam logic [3:0] S_TOUT  = 4'd13;

    localparam logic [2:0] LAST_PLANE = 3'd5;
    localparam logic [1:0] LAST_NRM   = 2'd2;
    localparam logic [1:0] LAST_COEF  = 2'd3;
    localparam logic [5:0] SQRT_LAST  = 6'd31;
    localparam logic [5:0] DIV_LAST   = 6'd62;

    logic [3:0] r_state, n_state;
    logic [2:0] r_plane, n_plane;
    logic [1:0] r_coef, n_coef;
    logic [5:0] r_step, n_step;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_plane = r_plane;
        n_coef  = r_coef;
        n_step  = r_step;
        o_cmd   = '0;
        o_cmd.plane = r_plane;
        o_cmd.coef  = r_coef;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_opcode == OP_LOAD) begin
                        o_cmd.load_col = 1'b1;
                        if (i_column_index == COL_LAST) begin
                            n_plane = '0;
                            n_state = S_BUILD;
                        end
                    end else if (i_visible_in) begin
                        o_cmd.capture = 1'b1;
                        o_cmd.acc_clr = 1'b1;
                        n_plane = '0;
                        n_coef  = '0;
                        n_state = S_TMUL;
                    end
                end
            end
            S_BUILD: begin
                o_cmd.build   = 1'b1;
                o_cmd.acc_clr = 1'b1;
                n_state = S_HALVE;
            end
            S_HALVE: begin
                o_cmd.halve = 1'b1;
                n_coef  = '0;
                n_state = S_SQM;
            end
            S_SQM: begin
                o_cmd.sq_mul = 1'b1;
                n_state = S_SQA;
            end
            S_SQA: begin
                o_cmd.acc_add = 1'b1;
                if (r_coef == LAST_NRM) begin
                    n_state = S_SQI;
                end else begin
                    n_coef  = r_coef + 2'd1;
                    n_state = S_SQM;
                end
            end
            S_SQI: begin
                o_cmd.sqrt_init = 1'b1;
                n_step  = '0;
                n_state = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                n_step = r_step + 6'd1;
                if (r_step == SQRT_LAST) begin
                    n_coef  = '0;
                    n_state = S_DIVI;
                end
            end
            S_DIVI: begin
                o_cmd.div_init = 1'b1;
                n_step  = '0;
                n_state = S_DIVS;
            end
            S_DIVS: begin
                o_cmd.div_step = 1'b1;
                n_step = r_step + 6'd1;
                if (r_step == DIV_LAST) begin
                    n_state = S_DIVW;
                end
            end
            S_DIVW: begin
                o_cmd.div_wr = 1'b1;
                if (r_coef == LAST_COEF) begin
                    if (r_plane == LAST_PLANE) begin
                        n_state = S_IDLE;
                    end else begin
                        n_plane = r_plane + 3'd1;
                        n_state = S_BUILD;
                    end
                end else begin
                    n_coef  = r_coef + 2'd1;
                    n_state = S_DIVI;
                end
            end
            S_TMUL: begin
                o_cmd.t_mul = 1'b1;
                n_state = S_TACC;
            end
            S_TACC: begin
                o_cmd.acc_add = 1'b1;
                if (r_coef == LAST_NRM) begin
                    n_state = S_TCMP;
                end else begin
                    n_coef  = r_coef + 2'd1;
                    n_state = S_TMUL;
                end
            end
            S_TCMP: begin
                if (i_sts.reject) begin
                    n_state = S_IDLE;
                end else if (r_plane == LAST_PLANE) begin
                    n_state = S_TOUT;
                end else begin
                    o_cmd.acc_clr = 1'b1;
                    n_plane = r_plane + 3'd1;
                    n_coef  = '0;
                    n_state = S_TMUL;
                end
            end
            S_TOUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_plane <= '0;
            r_coef  <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_plane <= n_plane;
            r_coef  <= n_coef;
            r_step  <= n_step;
        end
    end

endmodule

// ----- src/fsc_datapath.sv -----
// datapath: matrix and plane registers, shared multiplier, square root and divider
// depends on fsc_pkg
module fsc_datapath #(
    parameter int ID_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fsc_pkg::t_cmd       i_cmd,
    output fsc_pkg::t_sts       o_sts,
    input  logic                i_cfg_we,
    input  logic [30:0]         i_cfg_data,
    input  logic [1:0]          i_column_index,
    input  logic signed [31:0]  i_entry_row0,
    input  logic signed [31:0]  i_entry_row1,
    input  logic signed [31:0]  i_entry_row2,
    input  logic signed [31:0]  i_entry_row3,
    input  logic signed [31:0]  i_pos_x,
    input  logic signed [31:0]  i_pos_y,
    input  logic signed [31:0]  i_pos_z,
    input  logic [15:0]         i_object_id,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic [15:0]         o_kept_id
);
    import fsc_pkg::*;

    logic [30:0]        r_rad;
    logic signed [31:0] r_row3 [4];
    logic signed [31:0] r_rowr [3][4];
    logic signed [32:0] r_nrm [6][3];
    logic signed [47:0] r_w [6];
    logic signed [32:0] r_c [4];
    logic signed [31:0] r_pos [3];
    logic [15:0]        r_id;
    logic signed [65:0] r_prod;
    logic [63:0]        r_acc;
    logic [63:0]        r_s;
    logic [63:0]        r_res;
    logic [63:0]        r_bit;
    logic [31:0]        r_rem;
    logic [62:0]        r_dq;
    logic               r_ovalid;
    logic [15:0]        r_oid;

    logic [1:0]         sel_row;
    logic signed [32:0] c_new [4];
    logic               big;
    logic signed [32:0] mul_a, mul_b;
    logic [63:0]        sq_sum;
    logic               sq_ge;
    logic [32:0]        c_abs;
    logic [32:0]        rem_sh;
    logic               d_ge;
    logic [32:0]        rem_nx;
    logic               sat;
    logic [47:0]        mag;
    logic [47:0]        coef_val;
    logic signed [63:0] s_val;
    logic [63:0]        lim_sum;
    logic [15:0]        id_m;

    assign sel_row = i_cmd.plane[2:1];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            if (i_cmd.plane[0]) begin
                c_new[k] = 33'(r_row3[k]) - 33'(r_rowr[sel_row][k]);
            end else begin
                c_new[k] = 33'(r_row3[k]) + 33'(r_rowr[sel_row][k]);
            end
        end
        big = 1'b0;
        for (int k = 0; k < 3; k++) begin
            if (r_c[k] > 33'sd2147483648 || r_c[k] < -33'sd2147483648) begin
                big = 1'b1;
            end
        end
    end

    always_comb begin
        if (i_cmd.t_mul) begin
            mul_a = r_nrm[i_cmd.plane][i_cmd.coef];
            mul_b = 33'(r_pos[i_cmd.coef]);
        end else begin
            mul_a = r_c[i_cmd.coef];
            mul_b = r_c[i_cmd.coef];
        end
    end

    assign sq_sum = r_res + r_bit;
    assign sq_ge  = (r_s >= sq_sum);

    assign c_abs  = r_c[i_cmd.coef][32] ? 33'(-r_c[i_cmd.coef]) : 33'(r_c[i_cmd.coef]);
    assign rem_sh = {r_rem, r_dq[62]};
    assign d_ge   = (rem_sh >= {1'b0, r_res[31:0]});
    assign rem_nx = d_ge ? (rem_sh - {1'b0, r_res[31:0]}) : rem_sh;

    always_comb begin
        sat = |r_dq[62:47];
        mag = {1'b0, sat ? SAT_MAG : r_dq[46:0]};
        if (r_res == '0) begin
            coef_val = '0;
        end else if (r_c[i_cmd.coef][32]) begin
            coef_val = -mag;
        end else begin
            coef_val = mag;
        end
    end

    assign s_val   = $signed(r_acc) >>> 16;
    assign lim_sum = s_val + 64'({r_rad, 14'b0}) + 64'(r_w[i_cmd.plane]);

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            id_m[i] = (i < ID_BITS) ? r_id[i] : 1'b0;
        end
    end

    assign o_sts.reject   = lim_sum[63];
    assign o_sts.out_free = !r_ovalid || i_out_ready;
    assign o_out_valid    = r_ovalid;
    assign o_kept_id      = r_oid;

    // state with a defined reset value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rad    <= RAD_RESET;
            r_ovalid <= 1'b0;
            for (int k = 0; k < 4; k++) begin
                r_row3[k] <= '0;
                for (int r = 0; r < 3; r++) begin
                    r_rowr[r][k] <= '0;
                end
            end
            for (int p = 0; p < 6; p++) begin
                r_w[p] <= '0;
                for (int k = 0; k < 3; k++) begin
                    r_nrm[p][k] <= '0;
                end
            end
        end else begin
            if (i_cfg_we) begin
                r_rad <= i_cfg_data;
            end
            if (i_cmd.load_col) begin
                r_rowr[0][i_column_index] <= i_entry_row0;
                r_rowr[1][i_column_index] <= i_entry_row1;
                r_rowr[2][i_column_index] <= i_entry_row2;
                r_row3[i_column_index]    <= i_entry_row3;
            end
            if (i_cmd.div_wr) begin
                if (i_cmd.coef == 2'd3) begin
                    r_w[i_cmd.plane] <= coef_val;
                end else begin
                    r_nrm[i_cmd.plane][i_cmd.coef] <= coef_val[32:0];
                end
            end
            if (i_cmd.out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_pos[0] <= i_pos_x;
            r_pos[1] <= i_pos_y;
            r_pos[2] <= i_pos_z;
            r_id     <= i_object_id;
        end
        if (i_cmd.build) begin
            for (int k = 0; k < 4; k++) begin
                r_c[k] <= c_new[k];
            end
        end else if (i_cmd.halve && big) begin
            for (int k = 0; k < 4; k++) begin
                r_c[k] <= r_c[k] >>> 1;
            end
        end
        if (i_cmd.sq_mul || i_cmd.t_mul) begin
            r_prod <= mul_a * mul_b;
        end
        if (i_cmd.acc_clr) begin
            r_acc <= '0;
        end else if (i_cmd.acc_add) begin
            r_acc <= r_acc + r_prod[63:0];
        end
        if (i_cmd.sqrt_init) begin
            r_s   <= r_acc;
            r_res <= '0;
            r_bit <= 64'h4000_0000_0000_0000;
        end else if (i_cmd.sqrt_step) begin
            if (sq_ge) begin
                r_s   <= r_s - sq_sum;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
        if (i_cmd.div_init) begin
            r_rem <= '0;
            r_dq  <= {c_abs, 30'b0};
        end else if (i_cmd.div_step) begin
            r_rem <= rem_nx[31:0];
            r_dq  <= {r_dq[61:0], d_ge};
        end
        if (i_cmd.out_load) begin
            r_oid <= id_m;
        end
    end

endmodule

// ----- src/frustum_sphere_culler.sv -----
// Frustum sphere culler.
// Input channel (i_in_valid / o_in_ready) carries one word: a matrix column
// load (i_opcode 0) or an object test (i_opcode 1). Output channel
// (o_out_valid / i_out_ready) carries the id of each object kept.
// A load of columns 0 to 2 writes the column; a load of column 3 rebuilds
// the six planes, per plane: build, halve, square and sum the three normal
// terms, square root init and steps, and four divisions (init, steps,
// write) on the one-bit-per-cycle divider and two-bit-per-cycle square root.
// A test multiplies and accumulates each position term on the shared 33x33
// multiplier and compares once per plane, then loads the output register;
// a reject ends the test at that plane. Reset (i_rst_n low, synchronous)
// clears the matrix and planes to zero and sets the radius to 1.0; i_cfg_we
// writes the radius, and the user must use it only while idle, which the
// block does not enforce. A stalled receiver holds the output register;
// the next word is still taken and a kept result waits until it frees.
// depends on fsc_pkg, fsc_ctrl, fsc_datapath
module frustum_sphere_culler #(
    parameter int ID_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [30:0]         i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_opcode,
    input  logic [1:0]          i_column_index,
    input  logic signed [31:0]  i_entry_row0,
    input  logic signed [31:0]  i_entry_row1,
    input  logic signed [31:0]  i_entry_row2,
    input  logic signed [31:0]  i_entry_row3,
    input  logic signed [31:0]  i_pos_x,
    input  logic signed [31:0]  i_pos_y,
    input  logic signed [31:0]  i_pos_z,
    input  logic                i_visible_in,
    input  logic [15:0]         i_object_id,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [15:0]         o_kept_id
);
    import fsc_pkg::*;

    t_cmd cmd;
    t_sts sts;

    fsc_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_opcode       (i_opcode),
        .i_column_index (i_column_index),
        .i_visible_in   (i_visible_in),
        .i_sts          (sts),
        .o_cmd          (cmd)
    );

    fsc_datapath #(
        .ID_BITS (ID_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_column_index (i_column_index),
        .i_entry_row0   (i_entry_row0),
        .i_entry_row1   (i_entry_row1),
        .i_entry_row2   (i_entry_row2),
        .i_entry_row3   (i_entry_row3),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_pos_z        (i_pos_z),
        .i_object_id    (i_object_id),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_kept_id      (o_kept_id)
    );

endmodule

// ----- src/fsc_checker.sv -----
// port-level checker of the frustum sphere culler, bound to the top level
// depends on fsc_pkg and assert_macros.svh
`include "assert_macros.svh"

module fsc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        i_opcode,
    input logic        i_visible_in,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [15:0] o_kept_id
);
    import fsc_pkg::*;

    `FSC_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid)
    `FSC_ASSERT(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> $stable(o_kept_id))
    `FSC_ASSERT(a_test_busy, i_clk, i_rst_n, i_in_valid && o_in_ready && i_opcode == OP_TEST && i_visible_in |=> !o_in_ready)
    `FSC_ASSERT(a_rise_busy, i_clk, i_rst_n, $rose(o_out_valid) |-> $past(!o_in_ready))
    `FSC_ASSERT_RST(a_rst_idle, i_clk, !i_rst_n |=> !o_out_valid)

endmodule

bind frustum_sphere_culler fsc_checker u_chk (.*);
